[hw/rtl/assert_macros.svh]
// Assertion macros shared by the RTL of the pixel compositor.
// Depends on a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define CHK_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// Checks that a trigger is followed by a consequence on the next clock edge.
`define CHK_NEXT(lbl, trig, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/flc_pkg.sv]
// Package of the four layer pixel compositor: constants, register indexes,
// and the single-layer paint function. Depends on nothing.
`default_nettype none

package flc_pkg;

    localparam int unsigned PIX_W     = 8;
    localparam int unsigned NUM_LAYER = 4;

    localparam logic [PIX_W-1:0] TRANSPARENT_INDEX = 8'hFF;
    localparam logic [PIX_W-1:0] UNSET_PRIO        = 8'hFF;
    localparam logic [PIX_W-1:0] ALPHA_THRESHOLD   = 8'd180;
    localparam logic [PIX_W-1:0] BACKDROP_INDEX    = 8'd0;

    // Layer slots in enable-mask order.
    localparam int unsigned SLOT_BG2_LAYOUT  = 0;
    localparam int unsigned SLOT_BG2_OBJECTS = 1;
    localparam int unsigned SLOT_BG1_LAYOUT  = 2;
    localparam int unsigned SLOT_BG1_OBJECTS = 3;

    // Blend mode codes.
    typedef enum logic [1:0] {
        BLEND_NORMAL      = 2'd0,
        BLEND_TRANSLUCENT = 2'd1,
        BLEND_ADDITION    = 2'd2,
        BLEND_DARK        = 2'd3
    } t_blend;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        CFG_PRIORITY_MODE     = 3'd0,
        CFG_LAYER_ENABLE_MASK = 3'd1,
        CFG_BLEND_MODE_BITS   = 3'd2,
        CFG_ALPHA_BG2_LAYOUT  = 3'd3,
        CFG_ALPHA_BG2_OBJECTS = 3'd4,
        CFG_ALPHA_BG1_LAYOUT  = 3'd5,
        CFG_ALPHA_BG1_OBJECTS = 3'd6
    } t_cfg_idx;

    // A priority byte is high when it is nonzero and not the unset marker.
    function automatic logic is_high(input logic [PIX_W-1:0] prio);
        return (prio != '0) && (prio != UNSET_PRIO);
    endfunction

    // Paints one layer over the destination. A layer that is on and opaque
    // writes when it is not translucent, or its alpha passes the threshold,
    // or the destination is still transparent.
    function automatic logic [PIX_W-1:0] paint(
        input logic [PIX_W-1:0] dst,
        input logic             opaque_on,
        input logic             force_wr,
        input logic [PIX_W-1:0] src
    );
        logic wr;
        wr = opaque_on && (force_wr || (dst == TRANSPARENT_INDEX));
        return wr ? src : dst;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/four_layer_pixel_compositor_core.sv]
// Top level of the four layer pixel compositor: configuration registers and
// a three-stage pipeline. Depends on flc_pkg and assert_macros.svh.
//
//  Channel   Handshake            Payload
//  -------   ------------------   -------------------------------------------
//  input     i_valid / o_stall    four pixel indices, four priority bytes
//  output    o_valid / i_stall    o_out_pixel
//  config    i_cfg_we             i_cfg_idx, i_cfg_data
//
// An item passes from acceptance to o_valid through a flag stage, a
// stage that resolves each background and paints the bg2 layers, and an
// output stage that ranks the backgrounds and paints the bg1 layers.
// One item is accepted per cycle while the output is not stalled.
// A stall at the output backs up through the stages; o_stall rises only
// when all three stages are full. Reset clears the valid bits and loads
// the register reset values.
`default_nettype none
`include "assert_macros.svh"

module four_layer_pixel_compositor_core (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,

    input  wire logic                     i_cfg_we,
    input  wire logic [2:0]               i_cfg_idx,
    input  wire logic [7:0]               i_cfg_data,

    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [flc_pkg::PIX_W-1:0] i_bg1_layout_pixel,
    input  wire logic [flc_pkg::PIX_W-1:0] i_bg1_objects_pixel,
    input  wire logic [flc_pkg::PIX_W-1:0] i_bg2_layout_pixel,
    input  wire logic [flc_pkg::PIX_W-1:0] i_bg2_objects_pixel,
    input  wire logic [flc_pkg::PIX_W-1:0] i_bg1_layout_prio,
    input  wire logic [flc_pkg::PIX_W-1:0] i_bg1_objects_prio,
    input  wire logic [flc_pkg::PIX_W-1:0] i_bg2_layout_prio,
    input  wire logic [flc_pkg::PIX_W-1:0] i_bg2_objects_prio,

    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [flc_pkg::PIX_W-1:0]     o_out_pixel
);

    // Configuration registers.
    logic                          r_prio_mode;
    logic [flc_pkg::NUM_LAYER-1:0] r_enable;
    logic [7:0]                    r_blend;
    logic [flc_pkg::PIX_W-1:0]     r_alpha [flc_pkg::NUM_LAYER];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prio_mode <= 1'b0;
            r_enable    <= 4'hF;
            r_blend     <= 8'h00;
            for (int k = 0; k < flc_pkg::NUM_LAYER; k++) begin
                r_alpha[k] <= 8'hFF;
            end
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                flc_pkg::CFG_PRIORITY_MODE:     r_prio_mode <= i_cfg_data[0];
                flc_pkg::CFG_LAYER_ENABLE_MASK: r_enable    <= i_cfg_data[3:0];
                flc_pkg::CFG_BLEND_MODE_BITS:   r_blend     <= i_cfg_data;
                flc_pkg::CFG_ALPHA_BG2_LAYOUT:
                    r_alpha[flc_pkg::SLOT_BG2_LAYOUT]  <= i_cfg_data;
                flc_pkg::CFG_ALPHA_BG2_OBJECTS:
                    r_alpha[flc_pkg::SLOT_BG2_OBJECTS] <= i_cfg_data;
                flc_pkg::CFG_ALPHA_BG1_LAYOUT:
                    r_alpha[flc_pkg::SLOT_BG1_LAYOUT]  <= i_cfg_data;
                flc_pkg::CFG_ALPHA_BG1_OBJECTS:
                    r_alpha[flc_pkg::SLOT_BG1_OBJECTS] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Pipeline flow control: a stage moves when it is empty or the next moves.
    logic r_v1, r_v2, r_v3;
    logic adv1, adv2, adv3;
    logic in_accept;

    assign adv3      = !r_v3 || !i_stall;
    assign adv2      = !r_v2 || adv3;
    assign adv1      = !r_v1 || adv2;
    assign o_stall   = !adv1;
    assign in_accept = i_valid && adv1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) begin
                r_v1 <= i_valid;
            end
            if (adv2) begin
                r_v2 <= r_v1;
            end
            if (adv3) begin
                r_v3 <= r_v2;
            end
        end
    end

    // Stage 1 inputs arranged by slot, with per-layer flags.
    logic [flc_pkg::PIX_W-1:0]     w_pix  [flc_pkg::NUM_LAYER];
    logic [flc_pkg::PIX_W-1:0]     w_prio [flc_pkg::NUM_LAYER];
    logic [flc_pkg::NUM_LAYER-1:0] w_op, w_hi, w_frc;

    always_comb begin
        w_pix[flc_pkg::SLOT_BG2_LAYOUT]   = i_bg2_layout_pixel;
        w_pix[flc_pkg::SLOT_BG2_OBJECTS]  = i_bg2_objects_pixel;
        w_pix[flc_pkg::SLOT_BG1_LAYOUT]   = i_bg1_layout_pixel;
        w_pix[flc_pkg::SLOT_BG1_OBJECTS]  = i_bg1_objects_pixel;
        w_prio[flc_pkg::SLOT_BG2_LAYOUT]  = i_bg2_layout_prio;
        w_prio[flc_pkg::SLOT_BG2_OBJECTS] = i_bg2_objects_prio;
        w_prio[flc_pkg::SLOT_BG1_LAYOUT]  = i_bg1_layout_prio;
        w_prio[flc_pkg::SLOT_BG1_OBJECTS] = i_bg1_objects_prio;
        for (int k = 0; k < flc_pkg::NUM_LAYER; k++) begin
            w_op[k]  = r_enable[k] && (w_pix[k] != flc_pkg::TRANSPARENT_INDEX);
            w_hi[k]  = flc_pkg::is_high(w_prio[k]);
            w_frc[k] = (flc_pkg::t_blend'(r_blend[2*k +: 2]) != flc_pkg::BLEND_TRANSLUCENT)
                    || (r_alpha[k] > flc_pkg::ALPHA_THRESHOLD);
        end
    end

    logic [flc_pkg::PIX_W-1:0]     r1_pix [flc_pkg::NUM_LAYER];
    logic [flc_pkg::NUM_LAYER-1:0] r1_op, r1_hi, r1_frc;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r1_pix <= w_pix;
            r1_op  <= w_op;
            r1_hi  <= w_hi;
            r1_frc <= w_frc;
        end
    end

    // Stage 2: pick each background's pixel and paint the bg2 layers.
    logic [flc_pkg::PIX_W-1:0] w_bg1, w_bg2, w_paint2;
    logic                      w_pres1, w_pres2, w_hi1, w_hi2;

    always_comb begin
        w_pres1 = r1_op[flc_pkg::SLOT_BG1_OBJECTS] || r1_op[flc_pkg::SLOT_BG1_LAYOUT];
        w_pres2 = r1_op[flc_pkg::SLOT_BG2_OBJECTS] || r1_op[flc_pkg::SLOT_BG2_LAYOUT];
        if (r1_op[flc_pkg::SLOT_BG1_OBJECTS]) begin
            w_bg1 = r1_pix[flc_pkg::SLOT_BG1_OBJECTS];
            w_hi1 = r1_hi[flc_pkg::SLOT_BG1_OBJECTS];
        end else begin
            w_bg1 = r1_pix[flc_pkg::SLOT_BG1_LAYOUT];
            w_hi1 = r1_hi[flc_pkg::SLOT_BG1_LAYOUT];
        end
        if (r1_op[flc_pkg::SLOT_BG2_OBJECTS]) begin
            w_bg2 = r1_pix[flc_pkg::SLOT_BG2_OBJECTS];
            w_hi2 = r1_hi[flc_pkg::SLOT_BG2_OBJECTS];
        end else begin
            w_bg2 = r1_pix[flc_pkg::SLOT_BG2_LAYOUT];
            w_hi2 = r1_hi[flc_pkg::SLOT_BG2_LAYOUT];
        end
        w_paint2 = flc_pkg::paint(flc_pkg::BACKDROP_INDEX,
                                  r1_op[flc_pkg::SLOT_BG2_LAYOUT],
                                  r1_frc[flc_pkg::SLOT_BG2_LAYOUT],
                                  r1_pix[flc_pkg::SLOT_BG2_LAYOUT]);
        w_paint2 = flc_pkg::paint(w_paint2,
                                  r1_op[flc_pkg::SLOT_BG2_OBJECTS],
                                  r1_frc[flc_pkg::SLOT_BG2_OBJECTS],
                                  r1_pix[flc_pkg::SLOT_BG2_OBJECTS]);
    end

    logic [flc_pkg::PIX_W-1:0] r2_bg1, r2_bg2, r2_paint;
    logic [flc_pkg::PIX_W-1:0] r2_p1l, r2_p1o;
    logic                      r2_pres1, r2_pres2, r2_hi1, r2_hi2;
    logic [1:0]                r2_op, r2_frc;

    always_ff @(posedge i_clk) begin
        if (adv2 && r_v1) begin
            r2_bg1   <= w_bg1;
            r2_bg2   <= w_bg2;
            r2_pres1 <= w_pres1;
            r2_pres2 <= w_pres2;
            r2_hi1   <= w_hi1;
            r2_hi2   <= w_hi2;
            r2_paint <= w_paint2;
            r2_p1l   <= r1_pix[flc_pkg::SLOT_BG1_LAYOUT];
            r2_p1o   <= r1_pix[flc_pkg::SLOT_BG1_OBJECTS];
            r2_op    <= r1_op[flc_pkg::SLOT_BG1_OBJECTS:flc_pkg::SLOT_BG1_LAYOUT];
            r2_frc   <= r1_frc[flc_pkg::SLOT_BG1_OBJECTS:flc_pkg::SLOT_BG1_LAYOUT];
        end
    end

    // Stage 3: rank the backgrounds, finish painting, and select by mode.
    // When both are present, bg1 loses only when it is low and bg2 is high.
    logic [flc_pkg::PIX_W-1:0] w_prio_out, w_paint_out;

    always_comb begin
        if (!r2_pres1) begin
            w_prio_out = r2_pres2 ? r2_bg2 : flc_pkg::BACKDROP_INDEX;
        end else if (!r2_pres2) begin
            w_prio_out = r2_bg1;
        end else begin
            w_prio_out = (r2_hi1 || !r2_hi2) ? r2_bg1 : r2_bg2;
        end
        w_paint_out = flc_pkg::paint(r2_paint, r2_op[0], r2_frc[0], r2_p1l);
        w_paint_out = flc_pkg::paint(w_paint_out, r2_op[1], r2_frc[1], r2_p1o);
    end

    logic [flc_pkg::PIX_W-1:0] r3_pixel;

    always_ff @(posedge i_clk) begin
        if (adv3 && r_v2) begin
            r3_pixel <= r_prio_mode ? w_prio_out : w_paint_out;
        end
    end

    assign o_valid     = r_v3;
    assign o_out_pixel = r3_pixel;

    // Assertions.
    `CHK_ALWAYS(a_stall_only_full, !o_stall || (r_v1 && r_v2 && r_v3 && i_stall), "input stalled while pipeline has room")
    `CHK_ALWAYS(a_no_transparent_out, !o_valid || (o_out_pixel != flc_pkg::TRANSPARENT_INDEX), "result carries the transparent index")
    `CHK_NEXT(a_accept_fills_s1, in_accept, r_v1, "accepted item did not enter the first stage")

endmodule

`default_nettype wire
